/* rtl/gts_pkg.sv */
// Shared constants, tables and types for the Gaussian table sampler.
`timescale 1ns / 1ps

package gts_pkg;

  localparam int UNIFORM_BITS_DEF = 16;
  localparam int ROWS             = 53;
  localparam int CMP_ROWS         = ROWS - 1;
  localparam int ROW_IDX_W        = 6;
  localparam int DATA_W           = 16;
  localparam int Z_W              = 11;
  localparam int ZMAG_W           = 10;
  localparam int PROD_W           = 28;
  localparam int CFG_INDEX_W      = 2;
  localparam int CDF_W            = 14;
  localparam longint CDF_SCALE    = 10000;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MEAN  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STDEV = 2'd1;

  localparam logic signed [DATA_W-1:0] MEAN_RST  = 16'sd0;
  localparam logic [DATA_W-1:0]        STDEV_RST = 16'd256;

  // Normal CDF in units of 1/10000, rows compared by the search
  localparam logic [CDF_W-1:0] P_TAB [CMP_ROWS] = '{
    14'd5000, 14'd5040, 14'd5080, 14'd5120, 14'd5239, 14'd5319, 14'd5438, 14'd5517,
    14'd5636, 14'd5714, 14'd5832, 14'd5910, 14'd6026, 14'd6103, 14'd6217, 14'd6331,
    14'd6406, 14'd6517, 14'd6628, 14'd6700, 14'd6808, 14'd6915, 14'd7019, 14'd7123,
    14'd7224, 14'd7324, 14'd7422, 14'd7517, 14'd7611, 14'd7703, 14'd7823, 14'd7910,
    14'd8023, 14'd8106, 14'd8212, 14'd8315, 14'd8413, 14'd8508, 14'd8621, 14'd8708,
    14'd8810, 14'd8907, 14'd9015, 14'd9115, 14'd9207, 14'd9306, 14'd9406, 14'd9505,
    14'd9608, 14'd9706, 14'd9803, 14'd9901
  };

  // z magnitude in Q2.8 by stop row: the step of the row before, zero at the first row
  localparam logic [ZMAG_W-1:0] Z_MAG [ROWS] = '{
    10'd0,   10'd0,   10'd3,   10'd5,   10'd8,   10'd15,  10'd20,  10'd28,  10'd33,
    10'd41,  10'd46,  10'd54,  10'd59,  10'd67,  10'd72,  10'd79,  10'd87,  10'd92,
    10'd100, 10'd108, 10'd113, 10'd120, 10'd128, 10'd136, 10'd143, 10'd151, 10'd159,
    10'd166, 10'd174, 10'd182, 10'd189, 10'd200, 10'd207, 10'd218, 10'd225, 10'd236,
    10'd246, 10'd256, 10'd266, 10'd279, 10'd289, 10'd302, 10'd315, 10'd330, 10'd346,
    10'd361, 10'd379, 10'd399, 10'd422, 10'd451, 10'd484, 10'd527, 10'd596
  };

  // Control that travels with each word down the pipeline
  typedef struct packed {
    logic valid;
    logic neg;
  } ctl_t;

endpackage

/* rtl/gaussian_table_sampler.sv */
// Top level of the Gaussian table sampler: config registers and pipeline.
// A word taken with start comes out on done once it has passed every pipeline stage.
// Throughput: one word per cycle; busy stays low and the five-stage pipeline
// (fold, CDF compare, z lookup, multiply, round/saturate) never stalls.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset (rst, synchronous): clears pipeline valids, mean to 0, stdev to 1.0.
`timescale 1ns / 1ps

module gaussian_table_sampler #(
  parameter int UNIFORM_BITS = gts_pkg::UNIFORM_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [UNIFORM_BITS-1:0]             uniform_sample,
  output logic                                done,
  output logic signed [gts_pkg::DATA_W-1:0]   normal_sample,
  output logic signed [gts_pkg::Z_W-1:0]      z_step,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gts_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gts_pkg::DATA_W-1:0]          cfg_data
);

  logic signed [gts_pkg::DATA_W-1:0] mean_value;
  logic [gts_pkg::DATA_W-1:0]        std_deviation;
  gts_pkg::ctl_t                     ctl2;
  gts_pkg::ctl_t                     ctl3;
  logic [gts_pkg::CMP_ROWS-1:0]      therm;
  logic signed [gts_pkg::Z_W-1:0]    z3;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_value    <= gts_pkg::MEAN_RST;
      std_deviation <= gts_pkg::STDEV_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gts_pkg::REG_MEAN:  mean_value    <= signed'(cfg_data);
        gts_pkg::REG_STDEV: std_deviation <= cfg_data;
        default: ;
      endcase
    end
  end

  gts_fold_compare #(
    .UNIFORM_BITS(UNIFORM_BITS)
  ) u_fold_compare (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .sample   (uniform_sample),
    .ctl_out  (ctl2),
    .therm    (therm)
  );

  gts_zlookup u_zlookup (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl2),
    .therm   (therm),
    .ctl_out (ctl3),
    .z       (z3)
  );

  gts_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .ctl_in        (ctl3),
    .z             (z3),
    .mean_value    (mean_value),
    .std_deviation (std_deviation),
    .done          (done),
    .normal_sample (normal_sample),
    .z_step        (z_step)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted word did not produce a result after five cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##5 !done)
    else $error("result strobed without an accepted word");

endmodule

/* rtl/gts_fold_compare.sv */
// Fold stage and CDF threshold compare stage of the Gaussian table sampler.
`timescale 1ns / 1ps

module gts_fold_compare #(
  parameter int UNIFORM_BITS = gts_pkg::UNIFORM_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [UNIFORM_BITS-1:0]             sample,
  output gts_pkg::ctl_t                       ctl_out,
  output logic [gts_pkg::CMP_ROWS-1:0]        therm
);

  localparam longint unsigned FULL = (64'd1 << UNIFORM_BITS) - 64'd1;

  gts_pkg::ctl_t           ctl1;
  logic [UNIFORM_BITS-1:0] folded;
  logic [gts_pkg::CMP_ROWS-1:0] therm_next;

  // Fold at one half: full scale is odd, so the top bit marks the upper half
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1.valid <= in_valid;
      ctl1.neg   <= ~sample[UNIFORM_BITS-1];
    end
    folded <= sample[UNIFORM_BITS-1] ? sample : ~sample;
  end

  // t*10000 > p*M holds exactly when t > floor(p*M/10000)
  for (genvar g = 0; g < gts_pkg::CMP_ROWS; g++) begin : g_cmp
    localparam logic [UNIFORM_BITS-1:0] THR = UNIFORM_BITS'(
      (64'(gts_pkg::P_TAB[g]) * FULL) / 64'(gts_pkg::CDF_SCALE));
    assign therm_next[g] = (folded > THR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl1;
    end
    therm <= therm_next;
  end

  // Rising thresholds give a thermometer code: a set bit implies all lower bits set
  a_therm_mono: assert property (@(posedge clk) disable iff (rst)
    ctl_out.valid |-> (((therm >> 1) & ~therm) == '0))
    else $error("threshold compare is not a thermometer code");

endmodule

/* rtl/gts_zlookup.sv */
// Stop-row encode and signed z lookup stage of the Gaussian table sampler.
`timescale 1ns / 1ps

module gts_zlookup (
  input  logic                                clk,
  input  logic                                rst,
  input  gts_pkg::ctl_t                       ctl_in,
  input  logic [gts_pkg::CMP_ROWS-1:0]        therm,
  output gts_pkg::ctl_t                       ctl_out,
  output logic signed [gts_pkg::Z_W-1:0]      z
);

  logic [gts_pkg::CMP_ROWS+1:0]  edges;
  logic [gts_pkg::ZMAG_W-1:0]    zmag;
  logic signed [gts_pkg::Z_W-1:0] zpos;
  logic signed [gts_pkg::Z_W-1:0] z_next;

  // Stop row k is where the padded thermometer goes from one to zero
  always_comb begin
    edges = {1'b0, therm, 1'b1};
    zmag  = '0;
    for (int k = 0; k < gts_pkg::ROWS; k++) begin
      if (edges[k] && !edges[k+1]) begin
        zmag = zmag | gts_pkg::Z_MAG[k];
      end
    end
    zpos   = signed'({1'b0, zmag});
    z_next = ctl_in.neg ? -zpos : zpos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    z <= z_next;
  end

  a_z_range: assert property (@(posedge clk) disable iff (rst)
    ctl_out.valid |-> (z <= 11'sd596 && z >= -11'sd596))
    else $error("z step out of table range");

  a_z_sign: assert property (@(posedge clk) disable iff (rst)
    (ctl_in.valid && !ctl_in.neg) |=> (z >= 11'sd0))
    else $error("upper-half sample gave a negative z");

endmodule

/* rtl/gts_scale.sv */
// Multiply and round/saturate stages of the Gaussian table sampler.
`timescale 1ns / 1ps

module gts_scale (
  input  logic                                clk,
  input  logic                                rst,
  input  gts_pkg::ctl_t                       ctl_in,
  input  logic signed [gts_pkg::Z_W-1:0]      z,
  input  logic signed [gts_pkg::DATA_W-1:0]   mean_value,
  input  logic [gts_pkg::DATA_W-1:0]          std_deviation,
  output logic                                done,
  output logic signed [gts_pkg::DATA_W-1:0]   normal_sample,
  output logic signed [gts_pkg::Z_W-1:0]      z_step
);

  localparam int SUM_W = gts_pkg::PROD_W + 1;
  localparam int RES_W = SUM_W - 8;

  logic                                 valid4;
  logic signed [gts_pkg::PROD_W-1:0]    prod;
  logic signed [gts_pkg::Z_W-1:0]       z4;
  logic signed [SUM_W-1:0]              sum;
  logic signed [RES_W-1:0]              rounded;
  logic signed [gts_pkg::DATA_W-1:0]    sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
    end else begin
      valid4 <= ctl_in.valid;
    end
    prod <= gts_pkg::PROD_W'(signed'({1'b0, std_deviation}) * z);
    z4   <= z;
  end

  // Q13.16 sum plus half an LSB, then floor to Q13.8 and clamp to Q8.8
  always_comb begin
    sum = (SUM_W'(mean_value) <<< 8) + SUM_W'(prod) + SUM_W'(128);
    rounded = RES_W'(sum >>> 8);
    if (rounded > RES_W'(32767)) begin
      sat = 16'sh7FFF;
    end else if (rounded < -RES_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = rounded[gts_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid4;
    end
    normal_sample <= sat;
    z_step        <= z4;
  end

  a_zero_z: assert property (@(posedge clk) disable iff (rst)
    (valid4 && z4 == '0) |=> (normal_sample == $past(mean_value)))
    else $error("zero step must return the mean");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the Gaussian table sampler: CDF search, fold, scale and saturation.
`timescale 1ns / 1ps

module testbench;

  localparam int  HALF_PERIOD  = 6;
  localparam int  PIPE_LATENCY = 5;
  localparam int  CYCLE_LIMIT  = 100000;
  localparam int  PRINT_LIMIT  = 40;
  localparam int  SEARCH_ROWS  = 53;
  localparam longint FULL_SCALE = 65535;

  // Register indexes past the two real registers; writes there change nothing
  localparam logic [gts_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [gts_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [gts_pkg::DATA_W-1:0]        sample;
    logic signed [gts_pkg::DATA_W-1:0] normal;
    logic signed [gts_pkg::Z_W-1:0]    z;
  } gauss_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  logic [gts_pkg::DATA_W-1:0]          uniform_sample = '0;
  logic                                done;
  logic signed [gts_pkg::DATA_W-1:0]   normal_sample;
  logic signed [gts_pkg::Z_W-1:0]      z_step;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [gts_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [gts_pkg::DATA_W-1:0]          cfg_data = '0;

  // z step in Q2.8 and normal CDF in units of 1/10000, one entry per row
  int z_table [SEARCH_ROWS] = '{
    0, 3, 5, 8, 15, 20, 28, 33, 41, 46,
    54, 59, 67, 72, 79, 87, 92, 100, 108, 113,
    120, 128, 136, 143, 151, 159, 166, 174, 182, 189,
    200, 207, 218, 225, 236, 246, 256, 266, 279, 289,
    302, 315, 330, 346, 361, 379, 399, 422, 451, 484,
    527, 596, 25344
  };
  int cdf_table [SEARCH_ROWS] = '{
    5000, 5040, 5080, 5120, 5239, 5319, 5438, 5517, 5636, 5714,
    5832, 5910, 6026, 6103, 6217, 6331, 6406, 6517, 6628, 6700,
    6808, 6915, 7019, 7123, 7224, 7324, 7422, 7517, 7611, 7703,
    7823, 7910, 8023, 8106, 8212, 8315, 8413, 8508, 8621, 8708,
    8810, 8907, 9015, 9115, 9207, 9306, 9406, 9505, 9608, 9706,
    9803, 9901, 10000
  };

  logic signed [gts_pkg::DATA_W-1:0] mean_reg  = gts_pkg::MEAN_RST;
  logic [gts_pkg::DATA_W-1:0]        stdev_reg = gts_pkg::STDEV_RST;

  gauss_result_t expected_results [$];
  gauss_result_t want;
  int            errors = 0;
  int unsigned   cycles = 0;
  bit            quiet = 1'b0;

  gaussian_table_sampler dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .uniform_sample (uniform_sample),
    .done           (done),
    .normal_sample  (normal_sample),
    .z_step         (z_step),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic gauss_result_t predict_gauss(input logic [gts_pkg::DATA_W-1:0] s);
    longint t, zv, acc, r;
    int row;
    bit upper;
    gauss_result_t res;
    upper = (2 * longint'(s)) >= FULL_SCALE;
    t = upper ? longint'(s) : FULL_SCALE - longint'(s);
    row = 0;
    while (row < SEARCH_ROWS - 1 && t * 10000 > longint'(cdf_table[row]) * FULL_SCALE)
      row++;
    zv = (row == 0) ? 0 : longint'(z_table[row-1]);
    if (!upper)
      zv = -zv;
    acc = longint'(mean_reg) * 256 + longint'(stdev_reg) * zv + 128;
    r = acc >>> 8;
    if (r > 32767)
      r = 32767;
    if (r < -32768)
      r = -32768;
    res.sample = s;
    res.normal = r[gts_pkg::DATA_W-1:0];
    res.z      = zv[gts_pkg::Z_W-1:0];
    return res;
  endfunction

  // Sample whose folded value sits one above a row's CDF threshold, plus off
  function automatic logic [gts_pkg::DATA_W-1:0] boundary_sample(input int row,
                                                                input int off,
                                                                input bit lower);
    longint t;
    t = (longint'(cdf_table[row]) * FULL_SCALE) / 10000 + 1 + off;
    if (t < 32768)
      t = 32768;
    if (t > FULL_SCALE)
      t = FULL_SCALE;
    return lower ? gts_pkg::DATA_W'(FULL_SCALE - t) : gts_pkg::DATA_W'(t);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_sample(input logic [gts_pkg::DATA_W-1:0] s);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      uniform_sample <= gts_pkg::DATA_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    uniform_sample <= s;
    @(posedge clk);
    while (busy) begin
      @(negedge clk);
      @(posedge clk);
    end
    expected_results.push_back(predict_gauss(s));
    @(negedge clk);
  endtask

  // Drop start and let the pipeline empty
  task automatic settle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [gts_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [gts_pkg::DATA_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(negedge clk);
      @(posedge clk);
    end
    case (idx)
      gts_pkg::REG_MEAN:  mean_reg = data;
      gts_pkg::REG_STDEV: stdev_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_fold_and_search();
    send_sample(16'd0);
    send_sample(16'd65535);
    send_sample(16'd32767);
    send_sample(16'd32768);
    send_sample(16'd1);
    send_sample(16'd65534);
    send_sample(boundary_sample(1, -1, 1'b0));
    send_sample(boundary_sample(1, 0, 1'b0));
    send_sample(boundary_sample(25, 0, 1'b1));
    send_sample(boundary_sample(50, -1, 1'b0));
    send_sample(boundary_sample(51, 0, 1'b1));
    send_sample(boundary_sample(51, -1, 1'b1));
    send_sample(boundary_sample(51, 0, 1'b0));
  endtask

  task automatic test_saturation();
    write_reg(gts_pkg::REG_MEAN, 16'h7FFF);
    write_reg(gts_pkg::REG_STDEV, 16'hFFFF);
    send_sample(16'd65535);
    send_sample(16'd0);
    write_reg(gts_pkg::REG_MEAN, 16'h8000);
    send_sample(16'd0);
    send_sample(16'd65535);
    write_reg(gts_pkg::REG_STDEV, 16'h0000);
    write_reg(gts_pkg::REG_MEAN, 16'h1234);
    send_sample(16'd12345);
  endtask

  task automatic test_spare_index();
    write_reg(gts_pkg::REG_STDEV, 16'd384);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);
    send_sample(16'd60000);
    send_sample(16'd5000);
  endtask

  task automatic test_random_streams();
    int phase;
    int k;
    logic [gts_pkg::DATA_W-1:0] s;
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          write_reg(gts_pkg::REG_MEAN, 16'h0000);
          write_reg(gts_pkg::REG_STDEV, 16'd256);
        end
        2: begin
          write_reg(gts_pkg::REG_MEAN, 16'h7FFF);
          write_reg(gts_pkg::REG_STDEV, 16'hFFFF);
        end
        3: begin
          write_reg(gts_pkg::REG_MEAN, 16'h8000);
          write_reg(gts_pkg::REG_STDEV, 16'hFFFF);
        end
        4: begin
          write_reg(gts_pkg::REG_MEAN, gts_pkg::DATA_W'($urandom));
          write_reg(gts_pkg::REG_STDEV, 16'h0000);
        end
        5, 7: begin
          write_reg(gts_pkg::REG_MEAN, gts_pkg::DATA_W'($urandom));
          write_reg(gts_pkg::REG_STDEV, gts_pkg::DATA_W'($urandom));
        end
        default: begin
          write_reg(gts_pkg::REG_MEAN, gts_pkg::DATA_W'($urandom_range(0, 8192) - 4096));
          write_reg(gts_pkg::REG_STDEV, gts_pkg::DATA_W'($urandom_range(0, 2048)));
        end
      endcase
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  gts_pkg::DATA_W'($urandom));
      quiet = (phase == 9);
      for (k = 0; k < 110; k++) begin
        // Aim a share of the words at row thresholds, where the search decides
        if ($urandom_range(0, 9) < 3)
          s = boundary_sample($urandom_range(0, SEARCH_ROWS - 2),
                              int'($urandom_range(0, 3)) - 2, $urandom_range(0, 1));
        else
          s = gts_pkg::DATA_W'($urandom);
        send_sample(s);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= PRINT_LIMIT)
          $display("%0t unexpected result: expected none actual normal %0d z %0d",
                   $time, normal_sample, z_step);
      end else begin
        want = expected_results.pop_front();
        if (normal_sample !== want.normal) begin
          errors++;
          if (errors <= PRINT_LIMIT)
            $display("%0t normal_sample (input %0d): expected %0d actual %0d",
                     $time, want.sample, want.normal, normal_sample);
        end
        if (z_step !== want.z) begin
          errors++;
          if (errors <= PRINT_LIMIT)
            $display("%0t z_step (input %0d): expected %0d actual %0d",
                     $time, want.sample, want.z, z_step);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_fold_and_search();
    test_saturation();
    test_spare_index();
    test_random_streams();
    settle();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* gaussian_table_sampler.f */
rtl/gts_pkg.sv
rtl/gts_fold_compare.sv
rtl/gts_zlookup.sv
rtl/gts_scale.sv
rtl/gaussian_table_sampler.sv
verif/testbench.sv
